FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules. Each expects clk and
// rst_n in scope and stays quiet while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Codes and request/result types of the packet port register unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

  // operation codes
  localparam logic [1:0] OP_BUS_READ  = 2'd0;
  localparam logic [1:0] OP_BUS_WRITE = 2'd1;
  localparam logic [1:0] OP_NET_BYTE  = 2'd2;

  // bus read registers
  localparam logic [1:0] RD_STATUS = 2'd0;
  localparam logic [1:0] RD_LEN_HI = 2'd1;
  localparam logic [1:0] RD_LEN_LO = 2'd2;
  localparam logic [1:0] RD_DATA   = 2'd3;

  // bus write registers
  localparam logic [1:0] WR_TX_BYTE = 2'd0;
  localparam logic [1:0] WR_TX_END  = 2'd1;
  localparam logic [1:0] WR_DROP    = 2'd2;
  localparam logic [1:0] WR_IRQ_EN  = 2'd3;

  // bit position of the interrupt flag in the status byte and the enable write
  localparam int INT_BIT = 7;

  localparam int LEN_W = 12;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] net_byte;
    logic       net_last;
  } req_t;

  typedef struct packed {
    logic             mem_read;
    logic [7:0]       read_data;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             tx_frame_end;
    logic [LEN_W-1:0] tx_frame_len;
    logic             overflow;
    logic             rx_accepted;
    logic             irq;
  } res_t;

endpackage

`default_nettype wire

FILE: src/ppr_ram.sv
// ----------------------------------------------------------------------------
// ppr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/ppr_ctrl.sv
// ----------------------------------------------------------------------------
// ppr_ctrl
// Register file and update logic: decodes one request, updates the counters
// and status bits, and drives the receive store's write and read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_ctrl #(
  parameter int BUFFER_BYTES = 2048
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            req_valid,
  input  wire ppr_pkg::req_t                   req,
  output ppr_pkg::res_t                        res,
  output logic                                 ram_we,
  output logic [$clog2(BUFFER_BYTES)-1:0]      ram_waddr,
  output logic [7:0]                           ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(BUFFER_BYTES)-1:0]      ram_raddr
);

  import ppr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_BYTES);

  logic [CW-1:0] rx_fill_r, rx_fill_nxt;
  logic [CW-1:0] rx_remaining_r, rx_remaining_nxt;
  logic [AW-1:0] rx_read_ptr_r, rx_read_ptr_nxt;
  logic          stat_rx_r, stat_rx_nxt;
  logic          stat_int_r, stat_int_nxt;
  logic          irq_enable_r, irq_enable_nxt;
  logic [CW-1:0] tx_count_r, tx_count_nxt;
  logic [CW-1:0] fill_after;
  logic [15:0]   rem_wide;
  logic          store_byte;
  logic          fetch_byte;

  assign rem_wide = 16'(rx_remaining_r);

  // request decode and next state
  always_comb begin
    rx_fill_nxt      = rx_fill_r;
    rx_remaining_nxt = rx_remaining_r;
    rx_read_ptr_nxt  = rx_read_ptr_r;
    stat_rx_nxt      = stat_rx_r;
    stat_int_nxt     = stat_int_r;
    irq_enable_nxt   = irq_enable_r;
    tx_count_nxt     = tx_count_r;
    fill_after       = rx_fill_r;
    store_byte       = 1'b0;
    fetch_byte       = 1'b0;
    res              = '0;
    case (req.operation)
      OP_BUS_READ: begin
        case (req.reg_addr)
          RD_STATUS: begin
            res.read_data = {stat_int_r, 6'b0, stat_rx_r};
            stat_int_nxt  = 1'b0;
          end
          RD_LEN_HI: res.read_data = rem_wide[15:8];
          RD_LEN_LO: res.read_data = rem_wide[7:0];
          RD_DATA: begin
            if (rx_remaining_r != '0) begin
              fetch_byte       = 1'b1;
              res.mem_read     = 1'b1;
              rx_read_ptr_nxt  = rx_read_ptr_r + AW'(1);
              rx_remaining_nxt = rx_remaining_r - CW'(1);
              if (rx_remaining_r == CW'(1)) begin
                stat_rx_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      OP_BUS_WRITE: begin
        case (req.reg_addr)
          WR_TX_BYTE: begin
            if (tx_count_r < FULL) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = req.write_data;
              tx_count_nxt = tx_count_r + CW'(1);
            end else begin
              res.overflow = 1'b1;
            end
          end
          WR_TX_END: begin
            res.tx_frame_end = 1'b1;
            res.tx_frame_len = LEN_W'(tx_count_r);
            tx_count_nxt     = '0;
          end
          WR_DROP: begin
            stat_int_nxt     = 1'b0;
            stat_rx_nxt      = 1'b0;
            rx_remaining_nxt = '0;
          end
          WR_IRQ_EN: irq_enable_nxt = req.write_data[INT_BIT];
          default: ;
        endcase
      end
      OP_NET_BYTE: begin
        // bytes are taken only while no packet is held
        if (rx_remaining_r == '0) begin
          if (rx_fill_r < FULL) begin
            store_byte      = 1'b1;
            res.rx_accepted = 1'b1;
            fill_after      = rx_fill_r + CW'(1);
          end else begin
            res.overflow = 1'b1;
          end
          rx_fill_nxt = fill_after;
          if (req.net_last && fill_after != '0) begin
            rx_remaining_nxt = fill_after;
            rx_read_ptr_nxt  = '0;
            rx_fill_nxt      = '0;
            stat_rx_nxt      = 1'b1;
            stat_int_nxt     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.irq = stat_int_nxt & irq_enable_nxt;
  end

  // store ports: writes only while no packet is held, reads only while one is held,
  // so a read never meets a write to the same entry in one cycle; the last
  // write lands on the edge that marks the packet held, before any read of it
  assign ram_we    = req_valid & store_byte;
  assign ram_waddr = rx_fill_r[AW-1:0];
  assign ram_wdata = req.net_byte;
  assign ram_re    = req_valid & fetch_byte;
  assign ram_raddr = rx_read_ptr_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_fill_r      <= '0;
      rx_remaining_r <= '0;
      rx_read_ptr_r  <= '0;
      stat_rx_r      <= 1'b0;
      stat_int_r     <= 1'b0;
      irq_enable_r   <= 1'b0;
      tx_count_r     <= '0;
    end else if (req_valid) begin
      rx_fill_r      <= rx_fill_nxt;
      rx_remaining_r <= rx_remaining_nxt;
      rx_read_ptr_r  <= rx_read_ptr_nxt;
      stat_rx_r      <= stat_rx_nxt;
      stat_int_r     <= stat_int_nxt;
      irq_enable_r   <= irq_enable_nxt;
      tx_count_r     <= tx_count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/packet_port_rx_tx_registers_unit.sv
// Output: a result appears on the output stage in the cycle after its request
//   is accepted; packet data comes straight from the store's read register.
// Throughput: one request per cycle unless stalled; one store access (write or read) at most.
// Reset: synchronous, active low; clears counters, status bits, enable and
//   the output valid bit. Store contents are left as they are (no clearing pass).
// ----------------------------------------------------------------------------
// packet_port_rx_tx_registers_unit
// Byte-wide packet port: receive store, CPU register access, transmit pass.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_port_rx_tx_registers_unit #(
  parameter int BUFFER_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // write_data[7:0], net_byte[15:8]
  input  wire logic [3:0]  in_tuser,   // operation[1:0], reg_addr[3:2]
  input  wire logic        in_tlast,   // net_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // read_data[7:0], tx_byte[15:8],
                                       // tx_frame_len[27:16], overflow[28],
                                       // rx_accepted[29], irq[30], zero[31]
  output logic             out_tuser,  // tx_valid
  output logic             out_tlast   // tx_frame_end
);

  import ppr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  req_t          req;
  res_t          res;
  res_t          res_r;
  logic          out_valid_r;
  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    read_byte;

  // request unpacking
  assign req.operation  = in_tuser[1:0];
  assign req.reg_addr   = in_tuser[3:2];
  assign req.write_data = in_tdata[7:0];
  assign req.net_byte   = in_tdata[15:8];
  assign req.net_last   = in_tlast;

  assign in_tready = rst_n & (~out_valid_r | out_tready);
  assign accept    = in_tvalid & in_tready;

  ppr_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (accept),
    .req       (req),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  ppr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_rx_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= accept;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  // store read data holds while the stage stalls since no read is issued then
  assign read_byte  = res_r.mem_read ? ram_rdata : res_r.read_data;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.irq, res_r.rx_accepted, res_r.overflow,
                       res_r.tx_frame_len, res_r.tx_byte, read_byte};
  assign out_tuser  = res_r.tx_valid;
  assign out_tlast  = res_r.tx_frame_end;

endmodule

`default_nettype wire

FILE: src/ppr_chk.sv
// ----------------------------------------------------------------------------
// ppr_chk
// Port-level checks for the packet port register unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ppr_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  logic        out_stall;
  logic        in_accept;
  logic [33:0] out_bus;
  logic [3:0]  events;
  logic        len_pad_zero;

  // handshake and payload views
  assign out_stall    = out_tvalid && !out_tready;
  assign in_accept    = in_tvalid && in_tready;
  assign out_bus      = {out_tdata, out_tuser, out_tlast};
  assign events       = {out_tuser, out_tlast, out_tdata[28], out_tdata[29]};
  assign len_pad_zero = (out_tdata[27:16] == 12'd0) && !out_tdata[31];

  // a stalled result holds
  `PPR_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_bus), "stalled result changed")

  // every accepted request yields a result in the next cycle
  `PPR_ASSERT_NEXT(a_accept_result, in_accept, out_tvalid, "accepted request gave no result")

  // transmit byte, frame end, overflow and receive take are exclusive
  `PPR_ASSERT_IMPL(a_excl_events, out_tvalid, $onehot0(events), "conflicting event flags")

  // frame length only on frame end, pad bit zero
  `PPR_ASSERT_IMPL(a_len_on_end, out_tvalid && !out_tlast, len_pad_zero, "length without frame end")

endmodule

bind packet_port_rx_tx_registers_unit ppr_chk u_chk (.*);

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet port register unit. A directed table
// covers the reset state, the register map and the receive/transmit corner
// cases. A long frame then arrives during a long receiver hold-off, followed
// by its drain and a long transmit frame. A random mix of frames, CPU drains,
// transmit frames and stray requests follows. Every result is compared field
// by field with its typed table row or the bench's cycle-free port model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  localparam int BUF_BYTES    = 2048;
  localparam int TOTAL_ITEMS  = 1250;
  localparam int LONG_FRAME   = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_MAX    = 40;

  // operation code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             tx_frame_end;
    logic [LEN_W-1:0] tx_frame_len;
    logic             overflow;
    logic             rx_accepted;
    logic             irq;
  } port_result_t;

  typedef struct packed {
    req_t         r;
    logic         typed;
    port_result_t want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // port model state
  logic [7:0]       rx_mem [BUF_BYTES];
  logic [LEN_W-1:0] fill_cnt     = '0;
  logic [LEN_W-1:0] pkt_left     = '0;
  logic [10:0]      pkt_rd_idx   = '0;
  logic [LEN_W-1:0] tx_len_cnt   = '0;
  logic             stat_rx_bit  = 1'b0;
  logic             stat_int_bit = 1'b0;
  logic             irq_en_bit   = 1'b0;

  stim_row_t    offered_rows[$];
  port_result_t pending_results[$];
  int unsigned  errors     = 0;
  int unsigned  cycle_cnt  = 0;
  int unsigned  items_sent = 0;
  int           burst_left = 0;
  bit           hold_off_req = 1'b0;

  packet_port_rx_tx_registers_unit #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < PRINT_MAX)
      $display("cycle %0d: %s is %0h, expected %0h", cycle_cnt, what, got, want);
    errors++;
  endtask

  // one request through the port, updating the model state
  function automatic port_result_t predict_port(input req_t r);
    port_result_t res;
    res = '0;
    case (r.operation)
      OP_BUS_READ: begin
        case (r.reg_addr)
          RD_STATUS: begin
            res.read_data[INT_BIT] = stat_int_bit;
            res.read_data[0]       = stat_rx_bit;
            stat_int_bit = 1'b0;
          end
          RD_LEN_HI: res.read_data = {4'd0, pkt_left[11:8]};
          RD_LEN_LO: res.read_data = pkt_left[7:0];
          default: begin
            // empty data read returns zero and leaves state alone
            if (pkt_left != 0) begin
              res.read_data = rx_mem[pkt_rd_idx];
              pkt_rd_idx++;
              pkt_left--;
              if (pkt_left == 0) stat_rx_bit = 1'b0;
            end
          end
        endcase
      end
      OP_BUS_WRITE: begin
        case (r.reg_addr)
          WR_TX_BYTE: begin
            if (tx_len_cnt < BUF_BYTES) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = r.write_data;
              tx_len_cnt++;
            end else begin
              res.overflow = 1'b1;
            end
          end
          WR_TX_END: begin
            res.tx_frame_end = 1'b1;
            res.tx_frame_len = tx_len_cnt;
            tx_len_cnt = '0;
          end
          WR_DROP: begin
            // drops only the held packet, a partial frame keeps filling
            stat_int_bit = 1'b0;
            stat_rx_bit  = 1'b0;
            pkt_left     = '0;
          end
          default: irq_en_bit = r.write_data[INT_BIT];
        endcase
      end
      OP_NET_BYTE: begin
        // bytes are ignored while a packet is held
        if (pkt_left == 0) begin
          if (fill_cnt < BUF_BYTES) begin
            rx_mem[fill_cnt[10:0]] = r.net_byte;
            fill_cnt++;
            res.rx_accepted = 1'b1;
          end else begin
            res.overflow = 1'b1;
          end
          if (r.net_last && fill_cnt != 0) begin
            pkt_left     = fill_cnt;
            pkt_rd_idx   = '0;
            fill_cnt     = '0;
            stat_rx_bit  = 1'b1;
            stat_int_bit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.irq = stat_int_bit & irq_en_bit;
    return res;
  endfunction

  // accepted requests feed the model, accepted results are checked
  always @(posedge clk) begin : monitor
    req_t         r;
    stim_row_t    row;
    port_result_t pred;
    port_result_t got;
    port_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        r.operation  = in_tuser[1:0];
        r.reg_addr   = in_tuser[3:2];
        r.write_data = in_tdata[7:0];
        r.net_byte   = in_tdata[15:8];
        r.net_last   = in_tlast;
        pred = predict_port(r);
        row  = offered_rows.pop_front();
        pending_results.push_back(row.typed ? row.want : pred);
      end
      if (out_tvalid && out_tready) begin
        got.read_data    = out_tdata[7:0];
        got.tx_valid     = out_tuser;
        got.tx_byte      = out_tdata[15:8];
        got.tx_frame_end = out_tlast;
        got.tx_frame_len = out_tdata[27:16];
        got.overflow     = out_tdata[28];
        got.rx_accepted  = out_tdata[29];
        got.irq          = out_tdata[30];
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.tx_valid != want.tx_valid)
            report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
          if (got.tx_byte != want.tx_byte)
            report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
          if (got.tx_frame_end != want.tx_frame_end)
            report_mismatch("tx_frame_end", got.tx_frame_end, want.tx_frame_end);
          if (got.tx_frame_len != want.tx_frame_len)
            report_mismatch("tx_frame_len", got.tx_frame_len, want.tx_frame_len);
          if (got.overflow != want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
          if (got.rx_accepted != want.rx_accepted)
            report_mismatch("rx_accepted", got.rx_accepted, want.rx_accepted);
          if (got.irq != want.irq)
            report_mismatch("irq", got.irq, want.irq);
          if (out_tdata[31] != 1'b0)
            report_mismatch("tdata bit 31", out_tdata[31], 0);
        end
      end
    end
  end

  // receiver: ready patterns that change after a random span, plus one long hold-off
  initial begin : receiver
    int mode;
    int span;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= (i % 3 != 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // sender: bursts of back-to-back requests with random gaps in between
  task automatic offer_request(input req_t r, input logic typed,
                               input port_result_t want);
    stim_row_t row;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    row.r     = r;
    row.typed = typed;
    row.want  = want;
    offered_rows.push_back(row);
    in_tvalid <= 1'b1;
    in_tuser  <= {r.reg_addr, r.operation};
    in_tdata  <= {r.net_byte, r.write_data};
    in_tlast  <= r.net_last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // data goes to the field the operation uses, the unused fields are random
  task automatic send_req(input logic [1:0] op, input logic [1:0] addr,
                          input logic [7:0] data, input logic last);
    req_t r;
    r.operation  = op;
    r.reg_addr   = addr;
    r.write_data = (op == OP_BUS_WRITE) ? data : 8'($urandom);
    r.net_byte   = (op == OP_NET_BYTE) ? data : 8'($urandom);
    r.net_last   = (op == OP_NET_BYTE) ? last : 1'($urandom);
    offer_request(r, 1'b0, '0);
  endtask

  task automatic send_noise();
    send_req(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // received frame, optionally with stray requests mixed in
  task automatic net_frame(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_noise();
      send_req(OP_NET_BYTE, 2'($urandom), 8'($urandom), i == len - 1);
    end
  endtask

  // CPU side of a packet: status, length, data bytes, drop if left unread
  task automatic cpu_drain(input int len, input int stop);
    send_req(OP_BUS_READ, RD_STATUS, 8'h00, 1'b0);
    send_req(OP_BUS_READ, RD_LEN_HI, 8'h00, 1'b0);
    send_req(OP_BUS_READ, RD_LEN_LO, 8'h00, 1'b0);
    for (int i = 0; i < stop; i++) send_req(OP_BUS_READ, RD_DATA, 8'h00, 1'b0);
    if (stop < len) send_req(OP_BUS_WRITE, WR_DROP, 8'($urandom), 1'b0);
  endtask

  task automatic tx_frame(input int len);
    for (int i = 0; i < len; i++) send_req(OP_BUS_WRITE, WR_TX_BYTE, 8'($urandom), 1'b0);
    send_req(OP_BUS_WRITE, WR_TX_END, 8'($urandom), 1'b0);
  endtask

  function automatic stim_row_t mk_row(
    input logic [1:0] op, input logic [1:0] addr, input logic [7:0] wd,
    input logic [7:0] nb, input logic nl, input logic typed, input logic [7:0] rd,
    input logic txv, input logic [7:0] txb, input logic tend,
    input logic [LEN_W-1:0] tlen, input logic ovf, input logic acc, input logic irq);
    stim_row_t row;
    row.r    = '{operation: op, reg_addr: addr, write_data: wd, net_byte: nb,
                 net_last: nl};
    row.typed = typed;
    row.want  = '{read_data: rd, tx_valid: txv, tx_byte: txb, tx_frame_end: tend,
                  tx_frame_len: tlen, overflow: ovf, rx_accepted: acc, irq: irq};
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t dir_tab[$];
    int        pick;
    int        len;
    int        stop;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // op, reg, wdata, net byte, last | typed | rd, txv, txb, end, len, ovf, acc, irq
    // registers after reset, empty data read, ignored operation
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_STATUS, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_LEN_HI, 8'hff, 8'hff, 1, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_LEN_LO, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_DATA, 8'hff, 8'hff, 1, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_UNUSED, WR_IRQ_EN, 8'hff, 8'hff, 1, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    // enable interrupt, transmit extremes, frame ends incl. an empty one
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_IRQ_EN, 8'h80, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_TX_BYTE, 8'hff, 8'h00, 0, 1, 8'h00, 1, 8'hff, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_TX_BYTE, 8'h00, 8'hff, 1, 1, 8'h00, 1, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_TX_END, 8'h5a, 8'h00, 0, 1, 8'h00, 0, 8'h00, 1, 2, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_TX_END, 8'ha5, 8'h00, 0, 1, 8'h00, 0, 8'h00, 1, 0, 0, 0, 0));
    // two byte frame, then a byte arriving while the packet is held
    dir_tab.push_back(mk_row(OP_NET_BYTE, RD_STATUS, 8'h00, 8'hff, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 1, 0));
    dir_tab.push_back(mk_row(OP_NET_BYTE, WR_IRQ_EN, 8'hff, 8'h00, 1, 1, 8'h00, 0, 8'h00, 0, 0, 0, 1, 1));
    dir_tab.push_back(mk_row(OP_NET_BYTE, RD_STATUS, 8'h00, 8'ha5, 1, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1));
    // length, status (clears interrupt), data, drain, empty read
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_LEN_HI, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_LEN_LO, 8'h00, 8'h00, 0, 1, 8'h02, 0, 8'h00, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_STATUS, 8'h00, 8'h00, 0, 1, 8'h81, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_DATA, 8'h00, 8'h00, 0, 1, 8'hff, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_DATA, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_DATA, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_STATUS, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    // drop while a frame is partly filled, the frame still completes
    dir_tab.push_back(mk_row(OP_NET_BYTE, RD_LEN_HI, 8'h00, 8'h5a, 0, 0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_DROP, 8'h00, 8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_NET_BYTE, RD_LEN_LO, 8'h00, 8'hc3, 1, 1, 8'h00, 0, 8'h00, 0, 0, 0, 1, 1));
    // drop of a held packet, then nothing left to read
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_DROP, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_READ, RD_DATA, 8'h00, 8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_BUS_WRITE, WR_IRQ_EN, 8'h7f, 8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0));

    foreach (dir_tab[i]) offer_request(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].want);

    // long receiver hold-off while a long frame keeps coming
    hold_off_req = 1'b1;
    net_frame(LONG_FRAME, 1'b0);
    cpu_drain(LONG_FRAME, LONG_FRAME);
    tx_frame(LONG_FRAME);

    // random mix, mostly well-formed frames with random content
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        stop = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len)
                                           : len + $urandom_range(0, 1);
        net_frame(len, 1'b1);
        cpu_drain(len, stop);
      end else if (pick < 14) begin
        tx_frame($urandom_range(0, 20));
      end else if (pick < 16) begin
        send_req(OP_BUS_WRITE, WR_IRQ_EN, 8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) send_noise();
      end
    end
    in_tvalid <= 1'b0;

    // let the last results drain
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/ppr_pkg.sv
src/ppr_ram.sv
src/ppr_ctrl.sv
src/packet_port_rx_tx_registers_unit.sv
src/ppr_chk.sv
tb/tb.sv
